// ===== sv/lpq_pkg.sv =====
// shared constants and types for the linear priority queue
package lpq_pkg;

    localparam int DEPTH  = 16;
    localparam int PRIO_W = 4;
    localparam int TAG_W  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 4;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_entry;

endpackage

// ===== sv/linear_priority_queue_top.sv =====
// linear priority queue: sorted entry store with one compare and shift sequencer
//
// input stream: s_axis_tuser carries the operation (insert, remove lowest, list),
// s_axis_tdata the priority and tag of an insert. s_axis_tready is high only
// while the sequencer is idle, so one transaction is worked on at a time.
// output stream: each result goes out on m_axis with status in tuser and
// tlast marking the final result of the operation.
// the store is kept sorted by priority, ties in insertion order, in a 16 entry
// memory with one write port and one registered read port.
// insert: an empty queue takes the entry at once, else each entry with a
// higher priority number moves up one slot before the new entry is written.
// remove: takes the head entry. list: one result per cycle while not stalled.
// full and empty operations give a status only, an ignored operation no result.
// a stalled receiver holds the output register and the sequencer waits for it.
// reset clears the counters and state; the memory keeps its contents.
module linear_priority_queue_top
    import lpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // priority_req, tag, zero pad
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_priority, out_tag, position
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INS  = 3'd1;
    localparam logic [2:0] ST_PUT  = 3'd2;
    localparam logic [2:0] ST_REM  = 3'd3;
    localparam logic [2:0] ST_LST  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]        r_state;
    logic [IDX_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_fill;
    logic [IDX_W-1:0]  r_slot;
    logic [IDX_W-1:0]  r_idx;
    logic [POS_W-1:0]  r_pos;
    t_entry            r_new;
    t_entry            r_mem [DEPTH];
    t_entry            r_rdata;

    logic [STAT_W-1:0] r_pend_st;
    t_entry            r_pend_ent;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_st;
    t_entry            r_out_ent;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_last;

    logic              in_fire;
    logic              out_free;
    logic              out_load;
    logic [KIND_W-1:0] in_kind;
    t_entry            in_ent;
    logic              empty;
    logic              full;
    logic              shift;
    logic              lst_last;
    logic [IDX_W-1:0]  rd_addr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    t_entry            wdata;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_load      = out_free && ((r_state == ST_LST) || (r_state == ST_EMIT));
    assign in_kind       = s_axis_tuser;
    assign in_ent.prio   = s_axis_tdata[PRIO_W-1:0];
    assign in_ent.tag    = s_axis_tdata[PRIO_W+TAG_W-1:PRIO_W];
    assign empty         = (r_fill == '0);
    assign full          = (r_fill == CNT_W'(DEPTH));
    assign shift         = (r_rdata.prio > r_new.prio);
    assign lst_last      = ((CNT_W'(r_idx) + CNT_W'(1)) == r_fill);

    // memory port control
    always_comb begin
        rd_addr = r_idx;
        we      = 1'b0;
        waddr   = r_slot;
        wdata   = r_new;
        case (r_state)
            ST_IDLE: begin
                if (in_kind == KIND_INSERT) begin
                    rd_addr = IDX_W'(r_fill - CNT_W'(1));
                    waddr   = IDX_W'(r_fill);
                    wdata   = in_ent;
                    we      = in_fire && empty;
                end else begin
                    rd_addr = r_head;
                end
            end
            ST_INS: begin
                rd_addr = r_slot - IDX_W'(2);
                we      = 1'b1;
                wdata   = shift ? r_rdata : r_new;
            end
            ST_PUT: begin
                we = 1'b1;
            end
            ST_LST: begin
                rd_addr = out_free ? (r_idx + IDX_W'(1)) : r_idx;
            end
            default: begin
                rd_addr = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_new      <= in_ent;
                        r_pend_ent <= '0;
                        r_idx      <= r_head;
                        r_pos      <= '0;
                        case (in_kind)
                            KIND_INSERT: begin
                                r_slot <= IDX_W'(r_fill);
                                if (full) begin
                                    r_pend_st <= STAT_FULL;
                                    r_state   <= ST_EMIT;
                                end else if (empty) begin
                                    r_fill    <= r_fill + CNT_W'(1);
                                    r_pend_st <= STAT_OK;
                                    r_state   <= ST_EMIT;
                                end else begin
                                    r_state <= ST_INS;
                                end
                            end
                            KIND_REMOVE: begin
                                if (empty) begin
                                    r_pend_st <= STAT_EMPTY;
                                    r_state   <= ST_EMIT;
                                end else begin
                                    r_state <= ST_REM;
                                end
                            end
                            KIND_LIST: begin
                                if (empty) begin
                                    r_pend_st <= STAT_EMPTY;
                                    r_state   <= ST_EMIT;
                                end else begin
                                    r_state <= ST_LST;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_INS: begin
                    if (shift) begin
                        r_slot <= r_slot - IDX_W'(1);
                        if ((r_slot - IDX_W'(1)) == r_head) begin
                            r_state <= ST_PUT;
                        end
                    end else begin
                        r_fill    <= r_fill + CNT_W'(1);
                        r_pend_st <= STAT_OK;
                        r_state   <= ST_EMIT;
                    end
                end
                ST_PUT: begin
                    r_fill    <= r_fill + CNT_W'(1);
                    r_pend_st <= STAT_OK;
                    r_state   <= ST_EMIT;
                end
                ST_REM: begin
                    r_pend_st  <= STAT_OK;
                    r_pend_ent <= r_rdata;
                    if ((CNT_W'(r_head) + CNT_W'(1)) == r_fill) begin
                        r_head <= '0;
                        r_fill <= '0;
                    end else begin
                        r_head <= r_head + IDX_W'(1);
                    end
                    r_state <= ST_EMIT;
                end
                ST_LST: begin
                    if (out_free) begin
                        r_out_st    <= STAT_OK;
                        r_out_ent   <= r_rdata;
                        r_out_pos   <= r_pos;
                        r_out_last  <= lst_last;
                        r_idx       <= r_idx + IDX_W'(1);
                        r_pos       <= r_pos + POS_W'(1);
                        if (lst_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_st    <= r_pend_st;
                        r_out_ent   <= r_pend_ent;
                        r_out_pos   <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pos, r_out_ent.tag, r_out_ent.prio};
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the linear priority queue: random stream traffic checked against a predictor
`timescale 1ns / 100ps

module testbench;
    import lpq_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int REQUEST_TARGET = 380;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_answer;

    class priority_order_checker;
        t_entry  held[$];
        int      slots_used;
        t_answer pending[$];
        int      mismatches;

        function new();
            slots_used = 0;
            mismatches = 0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        // first entry holding the lowest priority number, so ties keep insertion order
        function int lowest_index(t_entry pool[$]);
            int best;
            best = 0;
            for (int i = 1; i < pool.size(); i++) begin
                if (pool[i].prio < pool[best].prio) begin
                    best = i;
                end
            end
            return best;
        endfunction

        function void apply_request(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio,
                                    logic [TAG_W-1:0] tag);
            t_answer a;
            t_entry  e;
            t_entry  rest[$];
            int      idx;
            int      rank;
            a = '0;
            a.last = 1'b1;
            case (kind)
                KIND_INSERT: begin
                    if (slots_used >= DEPTH) begin
                        a.status = STAT_FULL;
                    end else begin
                        e.prio = prio;
                        e.tag  = tag;
                        held.push_back(e);
                        slots_used++;
                        a.status = STAT_OK;
                    end
                    pending.push_back(a);
                end
                KIND_REMOVE: begin
                    if (held.size() == 0) begin
                        a.status = STAT_EMPTY;
                    end else begin
                        idx = lowest_index(held);
                        a.status = STAT_OK;
                        a.prio   = held[idx].prio;
                        a.tag    = held[idx].tag;
                        held.delete(idx);
                        if (held.size() == 0) begin
                            slots_used = 0;
                        end
                    end
                    pending.push_back(a);
                end
                KIND_LIST: begin
                    if (held.size() == 0) begin
                        a.status = STAT_EMPTY;
                        pending.push_back(a);
                    end else begin
                        rest = held;
                        rank = 0;
                        while (rest.size() > 0) begin
                            idx = lowest_index(rest);
                            a.status = STAT_OK;
                            a.prio   = rest[idx].prio;
                            a.tag    = rest[idx].tag;
                            a.pos    = POS_W'(rank);
                            rest.delete(idx);
                            a.last   = (rest.size() == 0);
                            pending.push_back(a);
                            rank++;
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        task check_answer(logic [STAT_W-1:0] status, logic [PRIO_W-1:0] prio,
                          logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos,
                          logic last);
            t_answer want;
            if (pending.size() == 0) begin
                report("unexpected result, status", 32'(status), 32'd0);
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) report("status", 32'(status), 32'(want.status));
            if (prio !== want.prio) report("out_priority", 32'(prio), 32'(want.prio));
            if (tag !== want.tag) report("out_tag", 32'(tag), 32'(want.tag));
            if (pos !== want.pos) report("position", 32'(pos), 32'(want.pos));
            if (last !== want.last) report("last", 32'(last), 32'(want.last));
        endtask

        function int held_count();
            return held.size();
        endfunction

        function int pending_count();
            return pending.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // priority_req, tag, zero pad
    logic [1:0]  s_axis_tuser  = '0;    // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // out_priority, out_tag, position
    logic [1:0]  m_axis_tuser;          // status
    logic        m_axis_tlast;

    priority_order_checker board = new();
    bit quiet_mode    = 1'b0;
    int requests_sent = 0;
    int cycle_count   = 0;

    linear_priority_queue_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                board.check_answer(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4],
                                   m_axis_tdata[23:20], m_axis_tlast);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [PRIO_W-1:0] prio,
                                input logic [TAG_W-1:0] tag);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, tag, prio};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        board.apply_request(kind, prio, tag);
        if (kind != KIND_UNUSED) requests_sent++;
    endtask

    // filling favors inserts, draining favors removes
    task automatic random_request(input bit filling);
        int               r;
        logic [KIND_W-1:0] kind;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        r = $urandom_range(0, 99);
        if (filling) begin
            kind = (r < 68) ? KIND_INSERT : (r < 82) ? KIND_REMOVE :
                   (r < 96) ? KIND_LIST : KIND_UNUSED;
        end else begin
            kind = (r < 10) ? KIND_INSERT : (r < 75) ? KIND_REMOVE :
                   (r < 96) ? KIND_LIST : KIND_UNUSED;
        end
        if ($urandom_range(0, 1) == 0) begin
            prio = PRIO_W'($urandom_range(0, 3));
        end else begin
            prio = PRIO_W'($urandom_range(0, 15));
        end
        tag = TAG_W'($urandom_range(0, 65535));
        send_request(kind, prio, tag);
    endtask

    initial begin : stimulus
        int len;
        int guard;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(KIND_REMOVE, 4'd0, 16'h0000);
        send_request(KIND_LIST, 4'd15, 16'hffff);
        send_request(KIND_UNUSED, 4'd3, 16'h1234);
        send_request(KIND_INSERT, 4'd15, 16'hffff);
        send_request(KIND_INSERT, 4'd0, 16'h0000);
        send_request(KIND_INSERT, 4'd15, 16'h0001);
        send_request(KIND_INSERT, 4'd0, 16'h8000);
        send_request(KIND_INSERT, 4'd7, 16'h5a5a);
        send_request(KIND_INSERT, 4'd8, 16'ha5a5);
        send_request(KIND_LIST, 4'd0, 16'h0000);
        send_request(KIND_REMOVE, 4'd0, 16'h0000);
        send_request(KIND_REMOVE, 4'd0, 16'h0000);
        send_request(KIND_UNUSED, 4'd15, 16'hffff);
        send_request(KIND_LIST, 4'd0, 16'h0000);
        repeat (4) send_request(KIND_REMOVE, 4'd0, 16'h0000);
        send_request(KIND_REMOVE, 4'd0, 16'h0000);
        send_request(KIND_LIST, 4'd0, 16'h0000);

        while (requests_sent < REQUEST_TARGET) begin
            quiet_mode = ($urandom_range(0, 4) == 0);
            len = $urandom_range(4, 26);
            repeat (len) random_request(1'b1);
            guard = 0;
            while (board.held_count() > 0 && guard < 60) begin
                random_request(1'b0);
                guard++;
            end
            if ($urandom_range(0, 2) == 0) random_request(1'b0);
        end
        s_axis_tvalid <= 1'b0;
        quiet_mode = 1'b0;

        while (board.pending_count() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
